/* src/rgby_pkg.sv */
// Shared types and constants for the RGB565 block to YUV 4:2:0 converter.
// No dependencies; used by the top level, rgby_lane and rgby_merge.
package rgby_pkg;

   // Pixel lanes: top left, top right, bottom left, bottom right
   localparam int NUM_LANES = 4;
   localparam int LANE_TL   = 0;
   localparam int LANE_TR   = 1;
   localparam int LANE_BL   = 2;
   localparam int LANE_BR   = 3;

   // Fixed point
   localparam int FRAC_BITS = 10;

   // Luma coefficients, studio range, scaled by 2^10
   localparam int Y_COEF_R  = 263;
   localparam int Y_COEF_G  = 516;
   localparam int Y_COEF_B  = 100;
   localparam int Y_BIAS    = (16 << FRAC_BITS) + (1 << (FRAC_BITS - 1));
   localparam int Y_ACC_W   = 18;

   // Chroma coefficients, scaled by 2^10
   localparam int CB_COEF_R = 152;
   localparam int CB_COEF_G = 298;
   localparam int CB_COEF_B = 450;
   localparam int CR_COEF_R = 450;
   localparam int CR_COEF_G = 377;
   localparam int CR_COEF_B = 73;
   localparam int C_ACC_W   = 22;
   localparam int C_HALF    = 1 << (FRAC_BITS - 1);
   localparam int C_OFFSET  = 128;

   // Sum of up to four 8-bit components
   localparam int SUM_W     = 10;
   // Chroma shift: 0, 1 or 2
   localparam int SHIFT_W   = 2;

   // What one lane hands to the merge stage
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } lane_out_type;

   // Stage load enables for the merge pipeline
   typedef struct packed {
      logic sum_load;
      logic prod_load;
      logic out_load;
   } merge_ctrl_type;

   // Result payload
   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } rsp_payload_type;

endpackage

/* src/rgby_if.sv */
// Valid/ready channel interfaces for the block converter: input and result.
// Depends on nothing; used by the top level and the checker.
interface rgby_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_top_left;
   logic [15:0] pixel_top_right;
   logic [15:0] pixel_bottom_left;
   logic [15:0] pixel_bottom_right;
   logic [1:0]  block_cols;
   logic [1:0]  block_rows;

   modport source (output valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
                   pixel_bottom_right, block_cols, block_rows, input ready);
   modport sink   (input valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
                   pixel_bottom_right, block_cols, block_rows, output ready);
endinterface

interface rgby_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_top_left;
   logic [7:0] luma_top_right;
   logic [7:0] luma_bottom_left;
   logic [7:0] luma_bottom_right;
   logic [7:0] chroma_blue;
   logic [7:0] chroma_red;

   modport source (output valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_blue, chroma_red, input ready);
   modport sink   (input valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_blue, chroma_red, output ready);
endinterface

/* src/rgb565_block_to_yuv420.sv */
// RGB565 2x2 block to YUV 4:2:0 converter. Takes one block per cycle while
// the result side is ready, and returns one result per block, in order. Four
// register stages: the four pixel lanes, the color sum, the chroma products,
// and the rounding/output register. Each stage advances on its own, so
// bubbles close up and a new block can be taken while a finished result
// waits, as long as an earlier stage is empty. Absent pixels of a clipped
// block give luma 0; block_cols or block_rows of 0 count as 1, of 3 count
// as 2. Depends on rgby_pkg, rgby_if, rgby_lane and rgby_merge.
module rgb565_block_to_yuv420 (
   input  logic        clock,
   input  logic        reset,
   rgby_req_if.sink    req_if,
   rgby_rsp_if.source  rsp_if
);

   localparam int NSTAGE = 4;

   logic [NSTAGE-1:0]             valid_ff, valid_in;
   logic [NSTAGE:0]               open;
   logic [rgby_pkg::SHIFT_W-1:0]  shift;
   logic [rgby_pkg::SHIFT_W-1:0]  shift_ff;
   logic                          two_cols, two_rows;
   logic [rgby_pkg::NUM_LANES-1:0] present;
   logic [15:0]                   pixels [rgby_pkg::NUM_LANES];
   rgby_pkg::lane_out_type        lanes [rgby_pkg::NUM_LANES];
   rgby_pkg::merge_ctrl_type      ctrl;
   rgby_pkg::rsp_payload_type     payload;

   // A stage can load when empty or when its item moves on
   always_comb begin
      open[NSTAGE] = rsp_if.ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         open[k] = !valid_ff[k] || open[k + 1];
      end
      valid_in[0] = open[0] ? req_if.valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = open[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready = open[0];

   // Decode the block shape
   assign two_cols = req_if.block_cols[1];
   assign two_rows = req_if.block_rows[1];
   assign shift    = {1'b0, two_cols} + {1'b0, two_rows};

   assign present[rgby_pkg::LANE_TL] = 1'b1;
   assign present[rgby_pkg::LANE_TR] = two_cols;
   assign present[rgby_pkg::LANE_BL] = two_rows;
   assign present[rgby_pkg::LANE_BR] = two_cols && two_rows;

   assign pixels[rgby_pkg::LANE_TL] = req_if.pixel_top_left;
   assign pixels[rgby_pkg::LANE_TR] = req_if.pixel_top_right;
   assign pixels[rgby_pkg::LANE_BL] = req_if.pixel_bottom_left;
   assign pixels[rgby_pkg::LANE_BR] = req_if.pixel_bottom_right;

   // Hold the shift alongside the lane stage
   always_ff @(posedge clock) begin
      if (open[0]) begin
         shift_ff <= shift;
      end
   end

   for (genvar i = 0; i < rgby_pkg::NUM_LANES; i++) begin : g_lane
      rgby_lane u_lane (
         .clock   (clock),
         .load    (open[0]),
         .pixel   (pixels[i]),
         .present (present[i]),
         .lane_ff (lanes[i])
      );
   end

   assign ctrl.sum_load  = open[1];
   assign ctrl.prod_load = open[2];
   assign ctrl.out_load  = open[3];

   rgby_merge u_merge (
      .clock      (clock),
      .ctrl       (ctrl),
      .lanes      (lanes),
      .shift      (shift_ff),
      .payload_ff (payload)
   );

   // Drive the result channel
   assign rsp_if.valid             = valid_ff[NSTAGE - 1];
   assign rsp_if.luma_top_left     = payload.luma_top_left;
   assign rsp_if.luma_top_right    = payload.luma_top_right;
   assign rsp_if.luma_bottom_left  = payload.luma_bottom_left;
   assign rsp_if.luma_bottom_right = payload.luma_bottom_right;
   assign rsp_if.chroma_blue       = payload.chroma_blue;
   assign rsp_if.chroma_red        = payload.chroma_red;

endmodule

/* src/rgby_lane.sv */
// One pixel lane: expand RGB565 to 8-bit RGB and compute studio-range luma.
// Depends on rgby_pkg. Output is registered; absent pixels give all zeros.
module rgby_lane (
   input  logic                 clock,
   input  logic                 load,
   input  logic [15:0]          pixel,
   input  logic                 present,
   output rgby_pkg::lane_out_type lane_ff
);

   logic [7:0]                  red;
   logic [7:0]                  green;
   logic [7:0]                  blue;
   logic [rgby_pkg::Y_ACC_W-1:0] luma_acc;
   rgby_pkg::lane_out_type      lane_in;

   // Expand fields into the high bits of each byte
   assign red   = {pixel[15:11], 3'b000};
   assign green = {pixel[10:5], 2'b00};
   assign blue  = {pixel[4:0], 3'b000};

   // Weighted sum with rounding and the 16 offset folded in
   assign luma_acc = rgby_pkg::Y_ACC_W'(rgby_pkg::Y_COEF_R * red)
                   + rgby_pkg::Y_ACC_W'(rgby_pkg::Y_COEF_G * green)
                   + rgby_pkg::Y_ACC_W'(rgby_pkg::Y_COEF_B * blue)
                   + rgby_pkg::Y_ACC_W'(rgby_pkg::Y_BIAS);

   // Zero everything for an absent pixel
   always_comb begin
      if (present) begin
         lane_in.luma  = luma_acc[rgby_pkg::FRAC_BITS +: 8];
         lane_in.red   = red;
         lane_in.green = green;
         lane_in.blue  = blue;
      end else begin
         lane_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule

/* src/rgby_merge.sv */
// Merge stage: sum lane colors, form Cb/Cr products, round and shift.
// Depends on rgby_pkg. Three register stages; luma rides along unchanged.
module rgby_merge (
   input  logic                    clock,
   input  rgby_pkg::merge_ctrl_type ctrl,
   input  rgby_pkg::lane_out_type  lanes [rgby_pkg::NUM_LANES],
   input  logic [rgby_pkg::SHIFT_W-1:0] shift,
   output rgby_pkg::rsp_payload_type payload_ff
);

   localparam int CW = rgby_pkg::C_ACC_W;

   // Sum stage registers
   logic [rgby_pkg::SUM_W-1:0]   sum_r_ff, sum_r_in;
   logic [rgby_pkg::SUM_W-1:0]   sum_g_ff, sum_g_in;
   logic [rgby_pkg::SUM_W-1:0]   sum_b_ff, sum_b_in;
   logic [rgby_pkg::SHIFT_W-1:0] sum_shift_ff;
   logic [31:0]                  sum_luma_ff, sum_luma_in;

   // Product stage registers
   logic signed [CW-1:0]         cb_acc_ff, cb_acc_in;
   logic signed [CW-1:0]         cr_acc_ff, cr_acc_in;
   logic [rgby_pkg::SHIFT_W-1:0] prod_shift_ff;
   logic [31:0]                  prod_luma_ff;

   logic signed [CW-1:0]         rs, gs, bs;
   logic signed [CW-1:0]         round_add;
   logic signed [CW-1:0]         cb_t, cr_t, cb_q, cr_q;
   logic [4:0]                   shamt;
   rgby_pkg::rsp_payload_type    payload_in;

   // Add up the lanes
   always_comb begin
      sum_r_in = '0;
      sum_g_in = '0;
      sum_b_in = '0;
      for (int i = 0; i < rgby_pkg::NUM_LANES; i++) begin
         sum_r_in = sum_r_in + rgby_pkg::SUM_W'(lanes[i].red);
         sum_g_in = sum_g_in + rgby_pkg::SUM_W'(lanes[i].green);
         sum_b_in = sum_b_in + rgby_pkg::SUM_W'(lanes[i].blue);
      end
      sum_luma_in = {lanes[rgby_pkg::LANE_TL].luma, lanes[rgby_pkg::LANE_TR].luma,
                     lanes[rgby_pkg::LANE_BL].luma, lanes[rgby_pkg::LANE_BR].luma};
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_load) begin
         sum_r_ff     <= sum_r_in;
         sum_g_ff     <= sum_g_in;
         sum_b_ff     <= sum_b_in;
         sum_shift_ff <= shift;
         sum_luma_ff  <= sum_luma_in;
      end
   end

   // Chroma products on the summed color
   assign rs = $signed({{(CW - rgby_pkg::SUM_W){1'b0}}, sum_r_ff});
   assign gs = $signed({{(CW - rgby_pkg::SUM_W){1'b0}}, sum_g_ff});
   assign bs = $signed({{(CW - rgby_pkg::SUM_W){1'b0}}, sum_b_ff});

   assign cb_acc_in = CW'(rgby_pkg::CB_COEF_B) * bs - CW'(rgby_pkg::CB_COEF_R) * rs
                    - CW'(rgby_pkg::CB_COEF_G) * gs;
   assign cr_acc_in = CW'(rgby_pkg::CR_COEF_R) * rs - CW'(rgby_pkg::CR_COEF_G) * gs
                    - CW'(rgby_pkg::CR_COEF_B) * bs;

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         cb_acc_ff     <= cb_acc_in;
         cr_acc_ff     <= cr_acc_in;
         prod_shift_ff <= sum_shift_ff;
         prod_luma_ff  <= sum_luma_ff;
      end
   end

   // Round, floor-shift by 10 plus the block shift, add the offset
   assign round_add = (CW'(rgby_pkg::C_HALF) <<< prod_shift_ff) - CW'(1);
   assign shamt     = 5'(rgby_pkg::FRAC_BITS) + {3'b000, prod_shift_ff};
   assign cb_t      = cb_acc_ff + round_add;
   assign cr_t      = cr_acc_ff + round_add;
   assign cb_q      = cb_t >>> shamt;
   assign cr_q      = cr_t >>> shamt;

   always_comb begin
      payload_in.luma_top_left     = prod_luma_ff[31:24];
      payload_in.luma_top_right    = prod_luma_ff[23:16];
      payload_in.luma_bottom_left  = prod_luma_ff[15:8];
      payload_in.luma_bottom_right = prod_luma_ff[7:0];
      payload_in.chroma_blue       = cb_q[7:0] + 8'(rgby_pkg::C_OFFSET);
      payload_in.chroma_red        = cr_q[7:0] + 8'(rgby_pkg::C_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         payload_ff <= payload_in;
      end
   end

endmodule

/* src/rgby_checker.sv */
// Port-level checks for the block converter, bound to the top level.
// Depends on rgby_if; watches the ports only.
module rgby_checker (
   input logic        clock,
   input logic        reset,
   rgby_req_if.sink   req_if,
   rgby_rsp_if.source rsp_if
);

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   // Hold a stalled result, its top-left luma and its chroma
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid
         && $stable(rsp_if.luma_top_left) && $stable(rsp_if.chroma_blue)
         && $stable(rsp_if.chroma_red))
      else $error("stalled result changed");

   // Top-left pixel is always present, so its luma is in studio range
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.luma_top_left >= 8'd16 && rsp_if.luma_top_left <= 8'd235)
      else $error("top-left luma outside studio range");

   // A bottom-right pixel implies a full block
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.luma_bottom_right != 8'd0
         |-> rsp_if.luma_top_right != 8'd0 && rsp_if.luma_bottom_left != 8'd0)
      else $error("bottom-right luma without a full block");

endmodule

bind rgb565_block_to_yuv420 rgby_checker u_rgby_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);
